// ===== hw/rtl/sdwq_pkg.sv =====
// Shared types and constants for the sorted delay wakeup queue.
// No dependencies; used by sorted_delay_wakeup_queue and tb_top.
package sdwq_pkg;

   // Request codes carried on req_type.
   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_QUERY = 2'd1,
      REQ_DELAY = 2'd2,
      REQ_UNTIL = 2'd3
   } req_kind_type;

   // Reply codes carried on rsp_reply_kind.
   typedef enum logic [1:0] {
      RSP_TIME    = 2'd0,
      RSP_WAKEUP  = 2'd1,
      RSP_RELEASE = 2'd2,
      RSP_ERROR   = 2'd3
   } rsp_kind_type;

   localparam int DEFAULT_QUEUE_DEPTH = 32;
   localparam int MAX_RESULTS         = 32;
   localparam int RUN_W               = $clog2(MAX_RESULTS + 1);

   // One table entry as held in the memory.
   typedef struct packed {
      logic [31:0] deadline;
      logic [7:0]  owner;
   } entry_type;

endpackage

// ===== hw/rtl/sorted_delay_wakeup_queue.sv =====
// Sorted delay wakeup queue: tick counter and a deadline-ordered table in one memory.
// Requests are handled one at a time: req_ready is high only in the idle state.
// An insert shifts later entries up one place; a reply held back by the receiver stalls the block.
// Table is a ring in a single-port-read, single-port-write RAM with registered reads.
// Synchronous reset clears the counter, the fill count and the ring head; no clearing pass.
module sorted_delay_wakeup_queue #(
   parameter int QUEUE_DEPTH = sdwq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_requester_id,
   input  logic signed [31:0] req_time_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_reply_kind,
   output logic [7:0]  rsp_reply_id,
   output logic [31:0] rsp_reply_time,
   output logic        rsp_last_of_run
);
   import sdwq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_EVAL, S_REPLY, S_INS_START, S_INS, S_T_READ, S_T_CMP, S_T_FIN
   } state_type;

   state_type           state_ff;
   logic [31:0]         tick_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [IDX_W-1:0]    head_ff;
   logic [1:0]          type_ff;
   logic [7:0]          id_ff;
   logic [31:0]         tv_ff;
   logic [31:0]         dl_ff;
   logic [IDX_W-1:0]    cmp_idx_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic                rd_more_ff;
   logic                cmp_vld_ff;
   logic [RUN_W-1:0]    run_ff;
   logic                pend_v_ff;
   logic [1:0]          pend_kind_ff;
   logic [7:0]          pend_id_ff;
   logic [31:0]         pend_time_ff;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_kind_ff;
   logic [7:0]          rsp_id_ff;
   logic [31:0]         rsp_time_ff;
   logic                rsp_last_ff;

   entry_type           mem [QUEUE_DEPTH];
   entry_type           rd_data_ff;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   entry_type           wr_data;

   logic                out_free;
   logic                rsp_load;
   logic [31:0]         dl_in;
   logic                due;
   logic                shift_up;

   // Map a position relative to the ring head to a memory address.
   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] hd,
                                             input logic [IDX_W-1:0] pos);
      logic [IDX_W:0] sum;
      sum = {1'b0, hd} + {1'b0, pos};
      if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic sgn_pos(input logic [31:0] v);
      return (v != 32'd0) && !v[31];
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign dl_in     = (type_ff == REQ_DELAY) ? (tv_ff + tick_ff) : tv_ff;
   assign due       = tick_ff > rd_data_ff.deadline;
   assign shift_up  = rd_data_ff.deadline > dl_ff;

   // A new reply is loaded into the output register this cycle.
   assign rsp_load = out_free && ((state_ff == S_REPLY)
                                  || (state_ff == S_T_CMP && due && pend_v_ff)
                                  || (state_ff == S_T_FIN && pend_v_ff));

   // Memory access control for insert walks and tick runs.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = head_ff;
      wr_en   = 1'b0;
      wr_addr = head_ff;
      wr_data = '{deadline: dl_ff, owner: id_ff};
      unique case (state_ff)
         S_EVAL: begin
            if (sgn_pos(dl_in) && !(dl_in < tick_ff) && count_ff == '0
                && !(type_ff == REQ_DELAY && !sgn_pos(tv_ff))) begin
               wr_en   = 1'b1;
               wr_data = '{deadline: dl_in, owner: id_ff};
            end
         end
         S_INS_START: begin
            rd_en   = 1'b1;
            rd_addr = phys(head_ff, IDX_W'(count_ff - 1'b1));
         end
         S_INS: begin
            if (cmp_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = phys(head_ff, cmp_idx_ff + 1'b1);
               if (shift_up) begin
                  wr_data = rd_data_ff;
                  if (rd_more_ff) begin
                     rd_en   = 1'b1;
                     rd_addr = phys(head_ff, rd_idx_ff);
                  end
               end
            end else begin
               wr_en   = 1'b1;
               wr_addr = head_ff;
            end
         end
         S_T_READ: begin
            rd_en = (count_ff != '0) && (run_ff != RUN_W'(MAX_RESULTS));
         end
         default: ;
      endcase
   end

   // Table memory with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Sequencer, counter, ring pointers and the reply register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tick_ff      <= '0;
         count_ff     <= '0;
         head_ff      <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         rd_more_ff   <= 1'b0;
         run_ff       <= '0;
      end else begin
         if (rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  type_ff <= req_type;
                  id_ff   <= req_requester_id;
                  tv_ff   <= req_time_value;
                  if (req_type == REQ_TICK) begin
                     tick_ff  <= tick_ff + 32'd1;
                     run_ff   <= '0;
                     state_ff <= S_T_READ;
                  end else if (req_type == REQ_QUERY) begin
                     pend_kind_ff <= RSP_TIME;
                     pend_id_ff   <= req_requester_id;
                     pend_time_ff <= tick_ff;
                     state_ff     <= S_REPLY;
                  end else begin
                     state_ff <= S_EVAL;
                  end
               end
            end
            S_EVAL: begin
               dl_ff      <= dl_in;
               pend_id_ff <= id_ff;
               if ((type_ff == REQ_DELAY && !sgn_pos(tv_ff)) || !sgn_pos(dl_in)
                   || (!(dl_in < tick_ff) && count_ff == CNT_W'(QUEUE_DEPTH))) begin
                  pend_kind_ff <= RSP_ERROR;
                  pend_time_ff <= '0;
                  state_ff     <= S_REPLY;
               end else if (dl_in < tick_ff) begin
                  pend_kind_ff <= RSP_RELEASE;
                  pend_time_ff <= tick_ff;
                  state_ff     <= S_REPLY;
               end else if (count_ff == '0) begin
                  count_ff <= count_ff + 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_INS_START;
               end
            end
            S_REPLY: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= pend_kind_ff;
                  rsp_id_ff    <= pend_id_ff;
                  rsp_time_ff  <= pend_time_ff;
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_INS_START: begin
               cmp_idx_ff <= IDX_W'(count_ff - 1'b1);
               rd_idx_ff  <= IDX_W'(count_ff - 2'd2);
               rd_more_ff <= count_ff > CNT_W'(1);
               cmp_vld_ff <= 1'b1;
               state_ff   <= S_INS;
            end
            S_INS: begin
               // Walk down from the tail, moving later deadlines up one place.
               if (cmp_vld_ff && shift_up) begin
                  cmp_vld_ff <= rd_more_ff;
                  cmp_idx_ff <= rd_idx_ff;
                  rd_idx_ff  <= rd_idx_ff - 1'b1;
                  rd_more_ff <= rd_idx_ff != '0;
               end else begin
                  cmp_vld_ff <= 1'b0;
                  count_ff   <= count_ff + 1'b1;
                  state_ff   <= S_IDLE;
               end
            end
            S_T_READ: begin
               if (count_ff != '0 && run_ff != RUN_W'(MAX_RESULTS)) begin
                  state_ff <= S_T_CMP;
               end else begin
                  state_ff <= S_T_FIN;
               end
            end
            S_T_CMP: begin
               // The held wakeup goes out here once the next entry is known to be due; else S_T_FIN sends it.
               if (!due) begin
                  state_ff <= S_T_FIN;
               end else if (!pend_v_ff || out_free) begin
                  if (pend_v_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_kind_ff  <= RSP_WAKEUP;
                     rsp_id_ff    <= pend_id_ff;
                     rsp_time_ff  <= tick_ff;
                     rsp_last_ff  <= 1'b0;
                  end
                  pend_v_ff  <= 1'b1;
                  pend_id_ff <= rd_data_ff.owner;
                  head_ff    <= phys(head_ff, IDX_W'(1));
                  count_ff   <= count_ff - 1'b1;
                  run_ff     <= run_ff + 1'b1;
                  state_ff   <= S_T_READ;
               end
            end
            S_T_FIN: begin
               if (!pend_v_ff) begin
                  state_ff <= S_IDLE;
               end else if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= RSP_WAKEUP;
                  rsp_id_ff    <= pend_id_ff;
                  rsp_time_ff  <= tick_ff;
                  rsp_last_ff  <= 1'b1;
                  pend_v_ff    <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reply_kind  = rsp_kind_ff;
   assign rsp_reply_id    = rsp_id_ff;
   assign rsp_reply_time  = rsp_time_ff;
   assign rsp_last_of_run = rsp_last_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH)) else $error("fill count beyond depth");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == RSP_ERROR |-> rsp_time_ff == 32'd0)
      else $error("error reply with nonzero time");
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_v_ff) else $error("held wakeup left behind");
   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff <= RUN_W'(MAX_RESULTS)) else $error("wakeup run too long");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for sorted_delay_wakeup_queue: directed and random requests,
// with a built-in predictor of the tick counter and the deadline-ordered table.
// Depends on sdwq_pkg and the sorted_delay_wakeup_queue RTL.
module tb_top;
   import sdwq_pkg::*;

   localparam int DEPTH      = DEFAULT_QUEUE_DEPTH;
   localparam int WATCHDOG   = 20000;
   localparam int SETTLE     = 2 * DEPTH + 20;

   typedef struct {
      rsp_kind_type kind;
      logic [7:0]   id;
      logic [31:0]  when;
      logic         last;
   } reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = REQ_QUERY;
   logic [7:0]  req_requester_id = '0;
   logic signed [31:0] req_time_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_reply_kind;
   logic [7:0]  rsp_reply_id;
   logic [31:0] rsp_reply_time;
   logic        rsp_last_of_run;

   // Predictor state: tick counter and the sorted table of waiting requesters.
   logic [31:0] now_ticks = '0;
   logic [31:0] wait_deadline[$];
   logic [7:0]  wait_owner[$];
   reply_type   pending_replies[$];

   int error_count = 0;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int quiet_cycles = 0;

   sorted_delay_wakeup_queue #(.QUEUE_DEPTH(DEPTH)) dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic bit is_positive(input logic [31:0] v);
      return v != 0 && !v[31];
   endfunction

   task automatic push_reply(input rsp_kind_type k, input logic [7:0] id,
                             input logic [31:0] t);
      reply_type r;
      r.kind = k;
      r.id   = id;
      r.when = t;
      r.last = 1'b1;
      pending_replies.push_back(r);
   endtask

   // Work out the replies that one accepted request causes.
   task automatic predict_replies(input req_kind_type k, input logic [7:0] id,
                                  input logic [31:0] tv);
      logic [31:0] deadline;
      int          released;
      int          pos;
      released = 0;
      deadline = tv;
      case (k)
         REQ_TICK: begin
            now_ticks = now_ticks + 1;
            while (wait_deadline.size() > 0 && released < MAX_RESULTS &&
                   now_ticks > wait_deadline[0]) begin
               if (released > 0) pending_replies[$].last = 1'b0;
               push_reply(RSP_WAKEUP, wait_owner[0], now_ticks);
               void'(wait_deadline.pop_front());
               void'(wait_owner.pop_front());
               released++;
            end
         end
         REQ_QUERY: push_reply(RSP_TIME, id, now_ticks);
         default: begin
            if (k == REQ_DELAY) deadline = tv + now_ticks;
            if ((k == REQ_DELAY && !is_positive(tv)) || !is_positive(deadline))
               push_reply(RSP_ERROR, id, '0);
            else if (deadline < now_ticks)
               push_reply(RSP_RELEASE, id, now_ticks);
            else if (wait_deadline.size() >= DEPTH)
               push_reply(RSP_ERROR, id, '0);
            else begin
               pos = 0;
               while (pos < wait_deadline.size() && wait_deadline[pos] <= deadline)
                  pos++;
               wait_deadline.insert(pos, deadline);
               wait_owner.insert(pos, id);
            end
         end
      endcase
   endtask

   // Send one request and wait for its transfer; valid stays high when no idle follows.
   task automatic send_request(input req_kind_type k, input logic [7:0] id,
                               input logic [31:0] tv);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= k;
      req_requester_id <= id;
      req_time_value   <= tv;
      do @(posedge clock); while (!req_ready);
      predict_replies(k, id, tv);
   endtask

   // Stop sending and wait until every expected reply has arrived and the block settles.
   task automatic drain_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Checking of every reply transfer against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0)
            report_mismatch("reply with nothing expected");
         else begin
            reply_type exp_r;
            exp_r = pending_replies.pop_front();
            if (rsp_reply_kind != exp_r.kind)
               report_mismatch($sformatf("kind %0d, expected %0d", rsp_reply_kind,
                                         exp_r.kind));
            if (rsp_reply_id != exp_r.id)
               report_mismatch($sformatf("id %0d, expected %0d", rsp_reply_id, exp_r.id));
            if (rsp_reply_time != exp_r.when)
               report_mismatch($sformatf("time %0d, expected %0d", rsp_reply_time,
                                         exp_r.when));
            if (rsp_last_of_run != exp_r.last)
               report_mismatch($sformatf("last %0b, expected %0b", rsp_last_of_run,
                                         exp_r.last));
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG) begin
         $display("[sorted_delay_wakeup_queue] ERROR");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // Queries, error cases, a past deadline and an equal deadline.
   task automatic test_directed();
      send_request(REQ_QUERY, 8'h00, '0);
      send_request(REQ_TICK, 8'hff, 32'hffff_ffff);
      send_request(REQ_QUERY, 8'hff, '0);
      send_request(REQ_DELAY, 8'h11, 32'd0);
      send_request(REQ_DELAY, 8'h12, 32'h8000_0000);
      send_request(REQ_DELAY, 8'h13, 32'hffff_ffff);
      send_request(REQ_DELAY, 8'h14, 32'h7fff_ffff);
      send_request(REQ_UNTIL, 8'h15, 32'd0);
      send_request(REQ_UNTIL, 8'h16, 32'h8000_0000);
      send_request(REQ_UNTIL, 8'h17, 32'hffff_ffff);
      send_request(REQ_TICK, 8'h00, '0);
      send_request(REQ_TICK, 8'h00, '0);
      send_request(REQ_UNTIL, 8'h18, 32'd1);
      send_request(REQ_UNTIL, 8'h19, now_ticks);
      send_request(REQ_DELAY, 8'h1a, 32'd1);
      send_request(REQ_UNTIL, 8'h1b, now_ticks + 1);
      send_request(REQ_DELAY, 8'h1c, 32'd3);
      send_request(REQ_TICK, 8'h00, '0);
      send_request(REQ_TICK, 8'h00, '0);
      send_request(REQ_TICK, 8'h00, '0);
      send_request(REQ_TICK, 8'h00, '0);
      send_request(REQ_TICK, 8'h00, '0);
   endtask

   // Fill the table past full, then release every entry with one tick.
   task automatic test_table_full();
      logic [31:0] target;
      target = now_ticks + 2;
      for (int i = 0; i <= DEPTH; i++)
         send_request(REQ_UNTIL, 8'(i + 8'h40), target);
      send_request(REQ_TICK, 8'h00, '0);
      send_request(REQ_TICK, 8'h00, '0);
      send_request(REQ_TICK, 8'h00, '0);
   endtask

   // Random traffic: mostly well-formed short delays, with noise and error cases.
   task automatic test_random(input int count, input int idle_p, input int stall_p);
      int          sel;
      logic [31:0] tv;
      idle_pct  = idle_p;
      stall_pct = stall_p;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(99);
         tv  = $urandom;
         if (sel < 36)
            send_request(REQ_TICK, 8'($urandom), tv);
         else if (sel < 46)
            send_request(REQ_QUERY, 8'($urandom), tv);
         else if (sel < 72)
            send_request(REQ_DELAY, 8'($urandom), 32'($urandom_range(1, 24)));
         else if (sel < 92)
            send_request(REQ_UNTIL, 8'($urandom),
                         now_ticks + 32'($urandom_range(0, 26)) - 32'd3);
         else if (sel < 96)
            send_request(REQ_DELAY, 8'($urandom), tv | 32'h8000_0000);
         else
            send_request(REQ_UNTIL, 8'($urandom), tv | 32'h8000_0000);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_full();
      drain_replies();
      test_random(65, 0, 0);
      drain_replies();
      test_random(65, 68, 0);
      test_random(65, 0, 68);
      drain_replies();
      test_random(65, 22, 22);
      // An absolute deadline at the top of the range stays queued for the rest of the run.
      send_request(REQ_UNTIL, 8'haa, 32'h7fff_ffff);
      idle_pct  = 0;
      stall_pct = 0;
      drain_replies();
      if (error_count == 0)
         $display("[sorted_delay_wakeup_queue] OK");
      else
         $display("[sorted_delay_wakeup_queue] ERROR");
      $finish;
   end
endmodule

// ===== filelist.f =====
hw/rtl/sdwq_pkg.sv
hw/rtl/sorted_delay_wakeup_queue.sv
tb/sv/tb_top.sv
